// ===== rtl/xte_pkg.sv =====
// ----------------------------------------------------------------------------
// xte_pkg
// Shared types, character constants and helpers for the XML text escape
// encoder.
// ----------------------------------------------------------------------------
package xte_pkg;

	localparam int unsigned CodeWidth = 16;
	localparam int unsigned ByteWidth = 7;
	localparam int unsigned MaxBytes  = 8;
	localparam int unsigned LenWidth  = $clog2(MaxBytes + 1);
	localparam int unsigned RemWidth  = $clog2(MaxBytes);

	localparam logic [CodeWidth-1:0] CodeAmp    = 16'h0026;
	localparam logic [CodeWidth-1:0] CodeLt     = 16'h003C;
	localparam logic [CodeWidth-1:0] CodeGt     = 16'h003E;
	localparam logic [CodeWidth-1:0] CodeQuot   = 16'h0022;
	localparam logic [CodeWidth-1:0] CodeApos   = 16'h0027;
	localparam logic [CodeWidth-1:0] PrintLow   = 16'h0020;
	localparam logic [CodeWidth-1:0] PrintHigh  = 16'h007E;
	localparam logic [CodeWidth-1:0] ShortLimit = 16'h0100;

	localparam logic [ByteWidth-1:0] ChAmp   = 7'h26;
	localparam logic [ByteWidth-1:0] ChHash  = 7'h23;
	localparam logic [ByteWidth-1:0] ChX     = 7'h78;
	localparam logic [ByteWidth-1:0] ChSemi  = 7'h3B;
	localparam logic [ByteWidth-1:0] ChA     = 7'h61;
	localparam logic [ByteWidth-1:0] ChM     = 7'h6D;
	localparam logic [ByteWidth-1:0] ChP     = 7'h70;
	localparam logic [ByteWidth-1:0] ChL     = 7'h6C;
	localparam logic [ByteWidth-1:0] ChG     = 7'h67;
	localparam logic [ByteWidth-1:0] ChT     = 7'h74;
	localparam logic [ByteWidth-1:0] ChQ     = 7'h71;
	localparam logic [ByteWidth-1:0] ChU     = 7'h75;
	localparam logic [ByteWidth-1:0] ChO     = 7'h6F;
	localparam logic [ByteWidth-1:0] ChS     = 7'h73;
	localparam logic [ByteWidth-1:0] ChZero  = 7'h30;
	localparam logic [ByteWidth-1:0] ChAlpha = 7'h37;

	typedef logic [MaxBytes-1:0][ByteWidth-1:0] byte_buf_t;

	typedef struct packed {
		byte_buf_t           bytes;
		logic [LenWidth-1:0] len;
	} enc_t;

	function automatic logic [ByteWidth-1:0] hex_char(input logic [3:0] nib);
		logic [ByteWidth-1:0] base;
		base = (nib < 4'd10) ? ChZero : ChAlpha;
		return base + {3'd0, nib};
	endfunction

endpackage

// ===== rtl/xte_encode.sv =====
// ----------------------------------------------------------------------------
// xte_encode
// Maps one code unit to its escaped byte run, first byte in slot zero,
// together with the run length.
// ----------------------------------------------------------------------------
module xte_encode import xte_pkg::*; (
	input  logic [CodeWidth-1:0] code,
	output enc_t                 enc
);

	always_comb begin
		enc.bytes = '0;
		enc.len   = LenWidth'(1);
		case (code)
			CodeAmp: begin
				enc.bytes[0] = ChAmp;
				enc.bytes[1] = ChA;
				enc.bytes[2] = ChM;
				enc.bytes[3] = ChP;
				enc.bytes[4] = ChSemi;
				enc.len      = LenWidth'(5);
			end
			CodeLt: begin
				enc.bytes[0] = ChAmp;
				enc.bytes[1] = ChL;
				enc.bytes[2] = ChT;
				enc.bytes[3] = ChSemi;
				enc.len      = LenWidth'(4);
			end
			CodeGt: begin
				enc.bytes[0] = ChAmp;
				enc.bytes[1] = ChG;
				enc.bytes[2] = ChT;
				enc.bytes[3] = ChSemi;
				enc.len      = LenWidth'(4);
			end
			CodeQuot: begin
				enc.bytes[0] = ChAmp;
				enc.bytes[1] = ChQ;
				enc.bytes[2] = ChU;
				enc.bytes[3] = ChO;
				enc.bytes[4] = ChT;
				enc.bytes[5] = ChSemi;
				enc.len      = LenWidth'(6);
			end
			CodeApos: begin
				enc.bytes[0] = ChAmp;
				enc.bytes[1] = ChA;
				enc.bytes[2] = ChP;
				enc.bytes[3] = ChO;
				enc.bytes[4] = ChS;
				enc.bytes[5] = ChSemi;
				enc.len      = LenWidth'(6);
			end
			default: begin
				if (code >= PrintLow && code <= PrintHigh) begin
					enc.bytes[0] = code[ByteWidth-1:0];
					enc.len      = LenWidth'(1);
				end else if (code < ShortLimit) begin
					enc.bytes[0] = ChAmp;
					enc.bytes[1] = ChHash;
					enc.bytes[2] = ChX;
					enc.bytes[3] = hex_char(code[7:4]);
					enc.bytes[4] = hex_char(code[3:0]);
					enc.bytes[5] = ChSemi;
					enc.len      = LenWidth'(6);
				end else begin
					enc.bytes[0] = ChAmp;
					enc.bytes[1] = ChHash;
					enc.bytes[2] = ChX;
					enc.bytes[3] = hex_char(code[15:12]);
					enc.bytes[4] = hex_char(code[11:8]);
					enc.bytes[5] = hex_char(code[7:4]);
					enc.bytes[6] = hex_char(code[3:0]);
					enc.bytes[7] = ChSemi;
					enc.len      = LenWidth'(8);
				end
			end
		endcase
	end

endmodule

// ===== rtl/xte_emit.sv =====
// ----------------------------------------------------------------------------
// xte_emit
// Holds one encoded run and shifts it out one byte per cycle, flagging the
// final byte. A new run loads in the cycle the previous one ends.
// ----------------------------------------------------------------------------
module xte_emit import xte_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  enc_t                 enc,
	output logic                 ready,
	output logic                 strobe,
	output logic [ByteWidth-1:0] out_byte,
	output logic                 last_of_run
);

	byte_buf_t           buf_s2;
	logic [RemWidth-1:0] rem_s2;
	logic                valid_s2;
	logic                last;

	assign last        = (rem_s2 == '0);
	assign ready       = !valid_s2 || last;
	assign strobe      = valid_s2;
	assign out_byte    = buf_s2[0];
	assign last_of_run = valid_s2 && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			rem_s2   <= '0;
		end else if (load && ready) begin
			valid_s2 <= 1'b1;
			rem_s2   <= RemWidth'(enc.len - LenWidth'(1));
		end else if (valid_s2) begin
			valid_s2 <= !last;
			rem_s2   <= rem_s2 - RemWidth'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load && ready) begin
			buf_s2 <= enc.bytes;
		end else if (valid_s2) begin
			buf_s2 <= buf_s2 >> ByteWidth;
		end
	end

endmodule

// ===== rtl/xml_text_escape_encoder.sv =====
// ----------------------------------------------------------------------------
// xml_text_escape_encoder
// Escapes 16-bit code units into XML-safe ASCII byte runs.
// ----------------------------------------------------------------------------
// A code unit is taken on char_code at a rising edge where start is high and
// busy is low. It is registered, encoded, and loaded into an output shifter
// that presents one byte per cycle on out_byte with strobe high; the final
// byte of each run also raises last_of_run. When the shifter is free, an
// item moves from the input register into the shifter, which then presents
// its first byte.
// A run is one to eight bytes long, and an item holds the output for its
// whole run; the single output byte lane sets the rate. While a run is
// still being shifted out, one more item can wait in the input register, and
// busy goes high only when that register is full and cannot move on.
// Printable characters therefore stream at one item per cycle, and the
// longest escapes at one item per eight-byte run.
// The receiver cannot hold results off: each byte stands for exactly one
// cycle. Reset empties both stages and drops any run in progress.
// ----------------------------------------------------------------------------
module xml_text_escape_encoder import xte_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [CodeWidth-1:0] char_code,
	output logic                 strobe,
	output logic [ByteWidth-1:0] out_byte,
	output logic                 last_of_run
);

	logic [CodeWidth-1:0] code_s1;
	logic                 valid_s1;
	logic                 emit_ready;
	enc_t                 enc;

	assign busy = valid_s1 && !emit_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (start && !busy) begin
			valid_s1 <= 1'b1;
		end else if (emit_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			code_s1 <= char_code;
		end
	end

	xte_encode u_encode (
		.code (code_s1),
		.enc  (enc)
	);

	xte_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (valid_s1),
		.enc         (enc),
		.ready       (emit_ready),
		.strobe      (strobe),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

// ===== rtl/xte_checker.sv =====
// ----------------------------------------------------------------------------
// xte_checker
// Port-level checks on the escaped byte stream of the encoder.
// ----------------------------------------------------------------------------
module xte_checker import xte_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 busy,
	input logic                 strobe,
	input logic [ByteWidth-1:0] out_byte,
	input logic                 last_of_run
);

	// Input stalls only while a multi-byte run is still going out.
	a_busy_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (strobe && !last_of_run))
		else $error("busy outside an unfinished run");

	// A run continues without gaps until its final byte.
	a_run_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_of_run) |=> strobe)
		else $error("gap inside a run");

	// Every multi-byte run opens with an ampersand.
	a_run_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_of_run && !$past(strobe && !last_of_run)) |->
		(out_byte == ChAmp))
		else $error("multi-byte run without leading ampersand");

	// Bytes after the first of a run are never an ampersand, and the run
	// closes with a semicolon.
	a_run_body: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && $past(strobe && !last_of_run)) |->
		(out_byte != ChAmp && (!last_of_run || out_byte == ChSemi)))
		else $error("malformed run body");

endmodule

bind xml_text_escape_encoder xte_checker u_xte_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.busy        (busy),
	.strobe      (strobe),
	.out_byte    (out_byte),
	.last_of_run (last_of_run)
);

// ===== tb/sv/xml_escape_checker.sv =====
// ----------------------------------------------------------------------------
// xml_escape_checker
// Watches the code unit input and the byte output of the XML text escape
// encoder, works out the escaped byte run for every accepted item and
// compares each emitted byte and its end-of-run flag in order.
// ----------------------------------------------------------------------------
module xml_escape_checker import xte_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [CodeWidth-1:0] char_code,
	input  logic                 strobe,
	input  logic [ByteWidth-1:0] out_byte,
	input  logic                 last_of_run,
	output int                   fail_count,
	output int                   bytes_checked,
	output int                   bytes_due
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CodeWidth-1:0] code;
		logic [ByteWidth-1:0] ch;
		logic                 last;
	} escaped_byte_t;

	escaped_byte_t due_bytes[$];

	function automatic string hex_digit(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return $sformatf("%c", 8'h30 + {4'd0, nib});
		end
		return $sformatf("%c", 8'h41 + {4'd0, nib} - 8'd10);
	endfunction

	function automatic void queue_escape_run(input logic [CodeWidth-1:0] code);
		string        txt;
		byte unsigned ch;
		escaped_byte_t eb;
		case (code)
			CodeAmp:  txt = "&amp;";
			CodeLt:   txt = "&lt;";
			CodeGt:   txt = "&gt;";
			CodeQuot: txt = "&quot;";
			CodeApos: txt = "&apos;";
			default: begin
				if (code >= PrintLow && code <= PrintHigh) begin
					txt = $sformatf("%c", code[7:0]);
				end else if (code < ShortLimit) begin
					txt = {"&#x", hex_digit(code[7:4]), hex_digit(code[3:0]), ";"};
				end else begin
					txt = {"&#x", hex_digit(code[15:12]), hex_digit(code[11:8]),
						hex_digit(code[7:4]), hex_digit(code[3:0]), ";"};
				end
			end
		endcase
		for (int i = 0; i < txt.len(); i++) begin
			ch = txt[i];
			eb.code = code;
			eb.ch = ch[ByteWidth-1:0];
			eb.last = (i == txt.len() - 1);
			due_bytes.push_back(eb);
		end
	endfunction

	always @(posedge clk) begin
		escaped_byte_t want;
		if (arst_n) begin
			if (start && !busy) begin
				queue_escape_run(char_code);
			end
			if (strobe) begin
				bytes_checked++;
				if (due_bytes.size() == 0) begin
					$display("%0t: unexpected byte %h last %b", $realtime, out_byte,
						last_of_run);
					fail_count++;
				end else begin
					want = due_bytes.pop_front();
					if (out_byte !== want.ch || last_of_run !== want.last) begin
						$display("%0t: code %h: expected byte %h last %b, got byte %h last %b",
							$realtime, want.code, want.ch, want.last, out_byte, last_of_run);
						fail_count++;
					end
				end
			end
		end
		bytes_due = due_bytes.size();
	end

endmodule

// ===== tb/sv/xml_text_escape_encoder_test.sv =====
// ----------------------------------------------------------------------------
// xml_text_escape_encoder_test
// Drives code units into the XML text escape encoder: a directed set of
// boundary codes and every markup character, then a random mix of printable,
// markup, short and long reference codes with random gaps between items.
// A separate checker predicts and compares the byte runs; this module
// gives the verdict.
// ----------------------------------------------------------------------------
module xml_text_escape_encoder_test import xte_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandomItems = 350;
	localparam int IdleLimit   = 500;
	localparam int DrainCycles = 30;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [CodeWidth-1:0] char_code = '0;
	logic                 busy;
	logic                 strobe;
	logic [ByteWidth-1:0] out_byte;
	logic                 last_of_run;

	int fail_count;
	int bytes_checked;
	int bytes_due;
	int items_sent = 0;
	int idle_cycles = 0;
	bit burst_mode = 1'b0;

	xml_text_escape_encoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.char_code  (char_code),
		.strobe     (strobe),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

	xml_escape_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.char_code    (char_code),
		.strobe       (strobe),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run),
		.fail_count   (fail_count),
		.bytes_checked(bytes_checked),
		.bytes_due    (bytes_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("%0t: no activity for %0d cycles", $realtime, IdleLimit);
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_code(input logic [CodeWidth-1:0] code);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		char_code <= code;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	function automatic logic [CodeWidth-1:0] random_code();
		logic [CodeWidth-1:0] markup[5];
		int pick;
		markup = '{CodeAmp, CodeLt, CodeGt, CodeQuot, CodeApos};
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			return CodeWidth'($urandom_range(PrintLow, PrintHigh));
		end else if (pick < 50) begin
			return markup[$urandom_range(0, 4)];
		end else if (pick < 70) begin
			return CodeWidth'($urandom_range(0, 255));
		end
		return CodeWidth'($urandom);
	endfunction

	initial begin
		logic [CodeWidth-1:0] directed[$];
		directed = '{16'h0000, 16'h0009, 16'h001F, 16'h0020, CodeQuot, CodeAmp,
			CodeApos, CodeLt, CodeGt, 16'h0041, 16'h007A, 16'h007E, 16'h007F,
			16'h0080, 16'h00A9, 16'h00FF, 16'h0100, 16'h1234, 16'h5A5A, 16'hA5A5,
			16'hABCD, 16'hFFFE, 16'hFFFF};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_code(directed[i]);
		end

		for (int n = 0; n < RandomItems; n++) begin
			if (n % 30 == 0) begin
				burst_mode = ($urandom_range(0, 2) == 0);
			end
			send_code(random_code());
		end
		start <= 1'b0;

		while (bytes_due != 0) @(negedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d code units: markup, printable, two- and four-digit references.",
			items_sent);
		$display("Checked %0d escaped bytes, with gaps and back-to-back bursts.",
			bytes_checked);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
